// ===== hdl/bdm_pkg.sv =====
// Shared constants and types of the bilinear Bayer demosaic block.
package bdm_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int PIX_W      = 8;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int SIZE_W     = 11;
    localparam int CFG_W      = 1;

    localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(316);
    localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(208);
    localparam logic [SIZE_W-1:0] SIZE_MIN     = SIZE_W'(3);

    typedef enum logic [CFG_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    typedef logic [PIX_W-1:0] pix_t;

endpackage

// ===== hdl/bdm_if.sv =====
// Request channels: Bayer sample input and RGB pixel output.
interface bdm_in_if;
    logic             valid;
    logic             ready;
    bdm_pkg::pix_t    bayer_sample;
    logic             frame_start;

    modport source (output valid, output bayer_sample, output frame_start, input ready);
    modport sink   (input valid, input bayer_sample, input frame_start, output ready);
endinterface

interface bdm_out_if;
    logic                         valid;
    logic                         ready;
    bdm_pkg::pix_t                red;
    bdm_pkg::pix_t                green;
    bdm_pkg::pix_t                blue;
    logic [bdm_pkg::COL_W-1:0]    out_column;
    logic [bdm_pkg::ROW_W-1:0]    out_row;
    logic                         run_end;
    logic                         frame_done;

    modport source (output valid, output red, output green, output blue, output out_column,
                    output out_row, output run_end, output frame_done, input ready);
    modport sink   (input valid, input red, input green, input blue, input out_column,
                    input out_row, input run_end, input frame_done, output ready);
endinterface

// ===== hdl/bdm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module bdm_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/bayer_demosaic_bilinear.sv =====
// Top level: bilinear BGGR demosaic with line store RAM and result sequencer.
//
//  channel   dir  handshake            payload
//  pix_in    in   valid/ready          bayer_sample, frame_start
//  pix_out   out  valid/ready          red, green, blue, out_column, out_row,
//                                      run_end, frame_done
//  cfg       in   cfg_we (no wait)     cfg_index, cfg_data
//
// One sample per cycle while pix_out is ready; a sample whose window hits a frame edge
// emits up to 9 requests, one per cycle from the sequencer while pix_out is ready,
// holding off input meanwhile. Path: line RAM read, window stage, output register.
// Reset clears counters, window and valid flags; the line RAM is not cleared.
// Output stall backs up through the output register into the sequencer and input.
module bayer_demosaic_bilinear (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [bdm_pkg::CFG_W-1:0]   cfg_index,
    input  logic [bdm_pkg::SIZE_W-1:0]  cfg_data,
    bdm_in_if.sink                      pix_in,
    bdm_out_if.source                   pix_out
);

    localparam int CW = bdm_pkg::COL_W;
    localparam int RW = bdm_pkg::ROW_W;
    localparam int SW = bdm_pkg::SIZE_W;
    localparam int PW = bdm_pkg::PIX_W;

    // configuration
    logic [SW-1:0] width_reg, height_reg;
    logic [SW-1:0] w_eff, h_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bdm_pkg::WIDTH_RESET;
            height_reg <= bdm_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (bdm_pkg::cfg_index_t'(cfg_index))
                bdm_pkg::CFG_FRAME_WIDTH:  width_reg  <= cfg_data;
                bdm_pkg::CFG_FRAME_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg < bdm_pkg::SIZE_MIN)
            w_eff = bdm_pkg::SIZE_MIN;
        else if (width_reg > SW'(bdm_pkg::MAX_WIDTH))
            w_eff = SW'(bdm_pkg::MAX_WIDTH);
        else
            w_eff = width_reg;
        if (height_reg < bdm_pkg::SIZE_MIN)
            h_eff = bdm_pkg::SIZE_MIN;
        else if (height_reg > SW'(bdm_pkg::MAX_HEIGHT))
            h_eff = SW'(bdm_pkg::MAX_HEIGHT);
        else
            h_eff = height_reg;
    end

    // stage 0: accept, position, RAM read
    logic          s1_valid_reg, s1_move, s2_free, in_fire;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [CW-1:0] c0, cx0, clo0, chi0;
    logic [RW-1:0] r0, cy0, rlo0, rhi0;
    logic          hasres0;

    assign pix_in.ready = !s1_valid_reg || s1_move;
    assign in_fire      = pix_in.valid && pix_in.ready;

    always_comb
    begin
        r0  = pix_in.frame_start ? '0 : row_reg;
        c0  = pix_in.frame_start ? '0 : col_reg;
        cy0 = r0 - RW'(1);
        cx0 = c0 - CW'(1);
        hasres0 = (r0 >= RW'(2)) && (c0 >= CW'(2)) && ({1'b0, r0} < h_eff)
                  && ({1'b0, c0} < w_eff);
        rlo0 = (cy0 == RW'(1)) ? '0 : cy0;
        rhi0 = ({1'b0, cy0} == h_eff - SW'(2)) ? RW'(h_eff - SW'(1)) : cy0;
        clo0 = (cx0 == CW'(1)) ? '0 : cx0;
        chi0 = ({1'b0, cx0} == w_eff - SW'(2)) ? CW'(w_eff - SW'(1)) : cx0;
        if ({1'b0, c0} + SW'(1) >= w_eff)
        begin
            col_next = '0;
            row_next = ({1'b0, r0} + SW'(1) >= h_eff) ? '0 : r0 + RW'(1);
        end
        else
        begin
            col_next = c0 + CW'(1);
            row_next = r0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_fire)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // stage 1: line data back from RAM
    logic          s1_hasres_reg, s1_rlast_reg, s1_clast_reg, s1_ypar_reg, s1_xpar_reg;
    logic [CW-1:0] s1_col_reg, s1_clo_reg, s1_chi_reg;
    logic [RW-1:0] s1_rlo_reg, s1_rhi_reg;
    logic [PW-1:0] s1_sample_reg;
    logic          fwd_hit_reg;
    logic [2*PW-1:0] fwd_data_reg, rd_data, wr_data;
    logic [PW-1:0] up_eff, mid_eff;

    assign up_eff  = fwd_hit_reg ? fwd_data_reg[2*PW-1:PW] : rd_data[2*PW-1:PW];
    assign mid_eff = fwd_hit_reg ? fwd_data_reg[PW-1:0]    : rd_data[PW-1:0];
    assign wr_data = {mid_eff, s1_sample_reg};
    assign s1_move = s1_valid_reg && (!s1_hasres_reg || s2_free);

    bdm_ram #(.DATA_W(2 * PW), .DEPTH(bdm_pkg::MAX_WIDTH)) u_line_ram (
        .clk     (clk),
        .wr_en   (s1_move),
        .wr_addr (s1_col_reg),
        .wr_data (wr_data),
        .rd_en   (in_fire),
        .rd_addr (c0),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (in_fire)
                s1_valid_reg <= 1'b1;
            else if (s1_move)
                s1_valid_reg <= 1'b0;
            if (in_fire)
                fwd_hit_reg <= s1_move && (s1_col_reg == c0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_col_reg    <= c0;
            s1_sample_reg <= pix_in.bayer_sample;
            s1_hasres_reg <= hasres0;
            s1_rlo_reg    <= rlo0;
            s1_rhi_reg    <= rhi0;
            s1_clo_reg    <= clo0;
            s1_chi_reg    <= chi0;
            s1_rlast_reg  <= ({1'b0, rhi0} == h_eff - SW'(1));
            s1_clast_reg  <= ({1'b0, chi0} == w_eff - SW'(1));
            s1_ypar_reg   <= cy0[0];
            s1_xpar_reg   <= cx0[0];
            fwd_data_reg  <= wr_data;
        end
    end

    // window shift and color interpolation
    logic [PW-1:0] win_reg [9];
    logic [PW-1:0] win_next [9];
    logic [PW:0]   hor, ver;
    logic [PW+1:0] diag, hv;
    logic [PW-1:0] red_c, green_c, blue_c;

    always_comb
    begin
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = up_eff;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = mid_eff;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = s1_sample_reg;
        hor  = {1'b0, win_next[3]} + {1'b0, win_next[5]};
        ver  = {1'b0, win_next[1]} + {1'b0, win_next[7]};
        diag = {2'b0, win_next[0]} + {2'b0, win_next[2]} + {2'b0, win_next[6]}
               + {2'b0, win_next[8]};
        hv   = {1'b0, hor} + {1'b0, ver};
        case ({s1_ypar_reg, s1_xpar_reg})
            2'b11:
            begin
                red_c = win_next[4]; green_c = hv[PW+1:2]; blue_c = diag[PW+1:2];
            end
            2'b10:
            begin
                red_c = hor[PW:1]; green_c = win_next[4]; blue_c = ver[PW:1];
            end
            2'b01:
            begin
                red_c = ver[PW:1]; green_c = win_next[4]; blue_c = hor[PW:1];
            end
            default:
            begin
                red_c = diag[PW+1:2]; green_c = hv[PW+1:2]; blue_c = win_next[4];
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
        end
        else if (s1_move)
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= win_next[i];
        end
    end

    // stage 2: result sequencer over the clamped edge block
    logic          s2_valid_reg, emit, s2_last;
    logic [PW-1:0] s2_red_reg, s2_green_reg, s2_blue_reg;
    logic [CW-1:0] s2_x_reg, s2_clo_reg, s2_chi_reg;
    logic [RW-1:0] s2_y_reg, s2_rhi_reg;
    logic          s2_rlast_reg, s2_clast_reg;
    logic          out_valid_reg;

    assign emit    = s2_valid_reg && (!out_valid_reg || pix_out.ready);
    assign s2_last = (s2_y_reg == s2_rhi_reg) && (s2_x_reg == s2_chi_reg);
    assign s2_free = !s2_valid_reg || (emit && s2_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s1_move && s1_hasres_reg)
            s2_valid_reg <= 1'b1;
        else if (emit && s2_last)
            s2_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && s1_hasres_reg)
        begin
            s2_red_reg   <= red_c;
            s2_green_reg <= green_c;
            s2_blue_reg  <= blue_c;
            s2_y_reg     <= s1_rlo_reg;
            s2_rhi_reg   <= s1_rhi_reg;
            s2_x_reg     <= s1_clo_reg;
            s2_clo_reg   <= s1_clo_reg;
            s2_chi_reg   <= s1_chi_reg;
            s2_rlast_reg <= s1_rlast_reg;
            s2_clast_reg <= s1_clast_reg;
        end
        else if (emit)
        begin
            if (s2_x_reg == s2_chi_reg)
            begin
                s2_x_reg <= s2_clo_reg;
                s2_y_reg <= s2_y_reg + RW'(1);
            end
            else
            begin
                s2_x_reg <= s2_x_reg + CW'(1);
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (pix_out.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pix_out.red        <= s2_red_reg;
            pix_out.green      <= s2_green_reg;
            pix_out.blue       <= s2_blue_reg;
            pix_out.out_column <= s2_x_reg;
            pix_out.out_row    <= s2_y_reg;
            pix_out.run_end    <= s2_last;
            pix_out.frame_done <= s2_last && s2_rlast_reg && s2_clast_reg;
        end
    end

    assign pix_out.valid = out_valid_reg;

    // checks
    a_seq_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg |-> (s2_x_reg <= s2_chi_reg) && (s2_y_reg <= s2_rhi_reg))
        else $error("sequencer position outside its block");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && pix_out.frame_done |-> pix_out.run_end)
        else $error("frame_done without run_end");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_hasres_reg && !s2_free |=> s1_valid_reg)
        else $error("window stage lost a sample while sequencer busy");

endmodule
